@@ rtl/dbc3_pkg.sv @@
// ----------------------------------------------------------------------------
// dbc3_pkg: shared definitions of the 3D dyadic box counter
// Field widths, register defaults, register index codes and the control
// word that travels with a voxel from the read stage to the update stage.
// ----------------------------------------------------------------------------
package dbc3_pkg;

   // Default sizing, handed to the top level as parameter defaults.
   localparam int MAX_DIM_DEF    = 512;
   localparam int MAX_SCALES_DEF = 8;

   // Field widths fixed by the interface.
   localparam int DIM_W       = 10;
   localparam int SCALES_W    = 4;
   localparam int VOXEL_W     = 8;
   localparam int SCALE_IDX_W = 3;
   localparam int COUNT_W     = 25;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = DIM_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Register reset values.
   localparam logic [DIM_W-1:0]    DIM_RST     = 10'd512;
   localparam logic [SCALES_W-1:0] SCALES_RST  = 4'd8;
   localparam logic [VOXEL_W-1:0]  OBJECT_RST  = 8'd255;

   // Register index codes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_X        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_Y        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_Z        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_SCALES   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_VALUE = 3'd4;

   // Control word of a voxel in the update stage.
   typedef struct packed {
      logic valid;
      logic hit;
      logic last;
   } s1_ctrl_type;

endpackage

@@ rtl/dbc3_ram.sv @@
// ----------------------------------------------------------------------------
// dbc3_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module dbc3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dyadic_box_counter_3d_top.sv @@
// ----------------------------------------------------------------------------
// dyadic_box_counter_3d_top: box counter over a binary voxel volume
// Counts, for every dyadic scale, the cubic boxes that contain at least one
// object voxel, and reports one count word per reported scale per volume.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_voxel
//   rsp_      out        rsp_valid/rsp_stall  rsp_scale_index, rsp_box_count,
//                                             rsp_last
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One voxel word is taken per cycle while req_stall is low. Each voxel first
// reads the mark memories, then is compared, counted and written back; the
// throughput of one word per cycle is set by the single read and the single
// write port of each scale's mark memory, with a one-entry forward path for
// back-to-back voxels that touch the same box column.
// After reset, and again after the final voxel of every volume, the mark
// memories are swept to zero, entry by entry, while req_stall is high.
// Configuration is taken at all times. The count words of a finished volume
// wait in their own registers, so rsp_stall holds up only the final voxel
// of the next volume.
// ----------------------------------------------------------------------------
module dyadic_box_counter_3d_top #(
   parameter int MAX_DIM    = dbc3_pkg::MAX_DIM_DEF,
   parameter int MAX_SCALES = dbc3_pkg::MAX_SCALES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // voxel input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dbc3_pkg::VOXEL_W-1:0]     req_voxel,
   // count output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dbc3_pkg::SCALE_IDX_W-1:0] rsp_scale_index,
   output logic [dbc3_pkg::COUNT_W-1:0]     rsp_box_count,
   output logic                             rsp_last,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dbc3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dbc3_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Position width, comparison width and scale index width.
   localparam int PW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW0  = $clog2(MAX_DIM + 1);
   localparam int CW   = (CW0 > dbc3_pkg::DIM_W) ? CW0 : dbc3_pkg::DIM_W;
   localparam int IW   = (MAX_SCALES > 1) ? $clog2(MAX_SCALES) : 1;
   // The finest scale has the largest mark memory; the sweep covers it.
   localparam int ROW0 = (MAX_DIM + 1) >> 1;
   localparam int AW0  = (ROW0 > 1) ? $clog2(ROW0) : 1;
   localparam int CLW  = 2 * AW0;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [dbc3_pkg::DIM_W-1:0]    dim_x_ff, dim_y_ff, dim_z_ff;
   logic [dbc3_pkg::SCALES_W-1:0] num_scales_ff;
   logic [dbc3_pkg::VOXEL_W-1:0]  object_value_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff        <= dbc3_pkg::DIM_RST;
         dim_y_ff        <= dbc3_pkg::DIM_RST;
         dim_z_ff        <= dbc3_pkg::DIM_RST;
         num_scales_ff   <= dbc3_pkg::SCALES_RST;
         object_value_ff <= dbc3_pkg::OBJECT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dbc3_pkg::CSR_DIM_X: begin
               dim_x_ff <= csr_wdata[dbc3_pkg::DIM_W-1:0];
            end
            dbc3_pkg::CSR_DIM_Y: begin
               dim_y_ff <= csr_wdata[dbc3_pkg::DIM_W-1:0];
            end
            dbc3_pkg::CSR_DIM_Z: begin
               dim_z_ff <= csr_wdata[dbc3_pkg::DIM_W-1:0];
            end
            dbc3_pkg::CSR_NUM_SCALES: begin
               num_scales_ff <= csr_wdata[dbc3_pkg::SCALES_W-1:0];
            end
            dbc3_pkg::CSR_OBJECT_VALUE: begin
               object_value_ff <= csr_wdata[dbc3_pkg::VOXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A dimension of zero behaves as one, and one above MAX_DIM as MAX_DIM.
   function automatic logic [CW-1:0] clamp_dim(input logic [dbc3_pkg::DIM_W-1:0] dim);
      logic [CW-1:0] wide;
      wide = CW'(dim);
      if (wide == '0) begin
         return CW'(1);
      end else if (wide > CW'(MAX_DIM)) begin
         return CW'(MAX_DIM);
      end
      return wide;
   endfunction

   logic [CW-1:0] dx_eff, dy_eff, dz_eff;

   assign dx_eff = clamp_dim(dim_x_ff);
   assign dy_eff = clamp_dim(dim_y_ff);
   assign dz_eff = clamp_dim(dim_z_ff);

   // ------------------------------------------------------------------
   // Raster position and end-of-volume detection
   // ------------------------------------------------------------------
   logic [PW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [PW-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic          end_x, end_y, end_z, end_now;
   logic          req_accept;
   logic          hit;

   dbc3_pkg::s1_ctrl_type s1_ctrl_ff, s1_ctrl_in;

   logic            clear_ff, clear_in;
   logic [CLW-1:0]  clear_cnt_ff, clear_cnt_in;
   logic            pending_ff;

   assign end_x   = (CW'(pos_x_ff) + CW'(1)) >= dx_eff;
   assign end_y   = (CW'(pos_y_ff) + CW'(1)) >= dy_eff;
   assign end_z   = (CW'(pos_z_ff) + CW'(1)) >= dz_eff;
   assign end_now = end_x && end_y && end_z;
   assign hit     = (req_voxel == object_value_ff);

   // Inputs wait during the sweep, while the final voxel is still being
   // counted, and when a final voxel would overwrite counts not yet sent.
   assign req_stall  = clear_ff || (s1_ctrl_ff.valid && s1_ctrl_ff.last) ||
                       (end_now && pending_ff);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (req_accept) begin
         priority if (end_now) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
         end else if (!end_x) begin
            pos_x_in = pos_x_ff + PW'(1);
         end else if (!end_y) begin
            pos_x_in = '0;
            pos_y_in = pos_y_ff + PW'(1);
         end else begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = pos_z_ff + PW'(1);
         end
      end
   end

   always_comb begin
      s1_ctrl_in.valid = req_accept;
      s1_ctrl_in.hit   = hit;
      s1_ctrl_in.last  = end_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         s1_ctrl_ff <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         pos_z_ff   <= pos_z_in;
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   // ------------------------------------------------------------------
   // Mark memories, one per scale, all updated in the same cycle
   // ------------------------------------------------------------------
   // An entry holds the z slab (plus one) in which its box column was last
   // counted; zero means the column has not been counted in this volume.
   logic [MAX_SCALES-1:0] inc_vec;

   for (genvar s = 0; s < MAX_SCALES; s++) begin : g_scale
      localparam int SH  = s + 1;
      localparam int ROW = (MAX_DIM + (1 << SH) - 1) >> SH;
      localparam int AW  = (ROW > 1) ? $clog2(ROW) : 1;
      localparam int TW  = $clog2(ROW + 1);

      logic [2*AW-1:0] rd_addr;
      logic [TW-1:0]   rd_tag;
      logic [TW-1:0]   ram_rdata;
      logic [2*AW-1:0] s1_addr_ff;
      logic [TW-1:0]   s1_tag_ff;
      logic            fwd_valid_ff;
      logic [2*AW-1:0] fwd_addr_ff;
      logic [TW-1:0]   fwd_tag_ff;
      logic            marked;
      logic            wr_en;
      logic [2*AW-1:0] wr_addr;
      logic [TW-1:0]   wr_data;

      assign rd_addr = {AW'(pos_y_ff >> SH), AW'(pos_x_ff >> SH)};
      assign rd_tag  = TW'(pos_z_ff >> SH) + TW'(1);

      // The previous voxel's write lands on the edge at which this voxel
      // was read, so a match on that entry takes the forwarded tag.
      always_comb begin
         if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
            marked = (fwd_tag_ff == s1_tag_ff);
         end else begin
            marked = (ram_rdata == s1_tag_ff);
         end
      end

      assign inc_vec[s] = s1_ctrl_ff.valid && s1_ctrl_ff.hit && !marked;

      assign wr_en   = clear_ff || inc_vec[s];
      assign wr_addr = clear_ff ? clear_cnt_ff[2*AW-1:0] : s1_addr_ff;
      assign wr_data = clear_ff ? '0 : s1_tag_ff;

      always_ff @(posedge clock) begin
         if (req_accept) begin
            s1_addr_ff <= rd_addr;
            s1_tag_ff  <= rd_tag;
         end
         fwd_addr_ff <= s1_addr_ff;
         fwd_tag_ff  <= s1_tag_ff;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fwd_valid_ff <= 1'b0;
         end else begin
            fwd_valid_ff <= inc_vec[s];
         end
      end

      dbc3_ram #(
         .WIDTH (TW),
         .DEPTH (1 << (2 * AW))
      ) u_marks (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (req_accept),
         .rd_addr (rd_addr),
         .rd_data (ram_rdata)
      );
   end

   // ------------------------------------------------------------------
   // Box counts and the sweep that clears the marks
   // ------------------------------------------------------------------
   logic [dbc3_pkg::COUNT_W-1:0] count_ff [MAX_SCALES];
   logic [dbc3_pkg::COUNT_W-1:0] count_in [MAX_SCALES];
   logic [dbc3_pkg::COUNT_W-1:0] res_ff   [MAX_SCALES];
   logic                         s1_final;

   assign s1_final = s1_ctrl_ff.valid && s1_ctrl_ff.last;

   always_comb begin
      for (int s = 0; s < MAX_SCALES; s++) begin
         if (inc_vec[s] && (count_ff[s] != dbc3_pkg::COUNT_MAX)) begin
            count_in[s] = count_ff[s] + dbc3_pkg::COUNT_W'(1);
         end else begin
            count_in[s] = count_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_SCALES; s++) begin
            count_ff[s] <= '0;
         end
      end else begin
         for (int s = 0; s < MAX_SCALES; s++) begin
            count_ff[s] <= s1_final ? '0 : count_in[s];
         end
      end
   end

   // The final voxel's own update is included in the captured counts.
   always_ff @(posedge clock) begin
      if (s1_final) begin
         for (int s = 0; s < MAX_SCALES; s++) begin
            res_ff[s] <= count_in[s];
         end
      end
   end

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      priority if (s1_final) begin
         clear_in     = 1'b1;
         clear_cnt_in = '0;
      end else if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + CLW'(1);
         if (&clear_cnt_ff) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Count words out, one per reported scale
   // ------------------------------------------------------------------
   logic [IW-1:0] idx_ff, last_idx_ff, last_idx_in;
   logic          rsp_accept;

   always_comb begin
      if (num_scales_ff == '0) begin
         last_idx_in = '0;
      end else if (32'(num_scales_ff) > MAX_SCALES) begin
         last_idx_in = IW'(MAX_SCALES - 1);
      end else begin
         last_idx_in = IW'(num_scales_ff - dbc3_pkg::SCALES_W'(1));
      end
   end

   assign rsp_accept = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         idx_ff      <= '0;
         last_idx_ff <= '0;
      end else if (s1_final) begin
         pending_ff  <= 1'b1;
         idx_ff      <= '0;
         last_idx_ff <= last_idx_in;
      end else if (rsp_accept) begin
         if (idx_ff == last_idx_ff) begin
            pending_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   assign rsp_valid       = pending_ff;
   assign rsp_scale_index = dbc3_pkg::SCALE_IDX_W'(idx_ff);
   assign rsp_box_count   = res_ff[idx_ff];
   assign rsp_last        = (idx_ff == last_idx_ff);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A final voxel never reaches the update stage while old counts wait.
   a_final_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_final |-> !pending_ff)
      else $error("final voxel would overwrite unsent counts");

   // The sweep and voxel updates never share the write ports.
   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_ctrl_ff.valid)
      else $error("voxel update during the mark sweep");

   // The sweep starts from entry zero right after the final voxel.
   a_clear_follows_final: assert property (@(posedge clock) disable iff (reset)
      s1_final |=> (clear_ff && (clear_cnt_ff == '0) && pending_ff))
      else $error("sweep or output did not start after the final voxel");

   // The output index stays within the reported scales.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (idx_ff <= last_idx_ff))
      else $error("output scale index beyond the last reported scale");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3D dyadic box counter
// Streams voxel words into the counter under randomised gaps and stalls,
// keeps a behavioural model of the counter in step with every accepted voxel
// and compares each count word that comes out with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_DIM    = dbc3_pkg::MAX_DIM_DEF;
   localparam int MAX_SCALES = dbc3_pkg::MAX_SCALES_DEF;

   // Cycles allowed after the last count word before a register write or the
   // end of the run; the pipeline is only two stages deep.
   localparam int QUIET_CYCLES = 16;

   // Were every voxel word of the run to close a volume, each would cost a
   // sweep of the mark memories plus eight count words under heavy stalls.
   // The limit is four times that cost for some 160 such words.
   localparam int unsigned CYCLE_LIMIT = 4 * 160 * (65_536 + 8 * 100);

   // Register indexes above the last defined one decode to nothing.
   localparam logic [dbc3_pkg::CSR_INDEX_W-1:0] CSR_TOP_INDEX = '1;

   typedef struct packed {
      logic [dbc3_pkg::SCALE_IDX_W-1:0] scale;
      logic [dbc3_pkg::COUNT_W-1:0]     count;
      logic                             last;
   } count_word_type;

   logic                             clock;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [dbc3_pkg::VOXEL_W-1:0]     req_voxel = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [dbc3_pkg::SCALE_IDX_W-1:0] rsp_scale_index;
   logic [dbc3_pkg::COUNT_W-1:0]     rsp_box_count;
   logic                             rsp_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [dbc3_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dbc3_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   dyadic_box_counter_3d_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_voxel       (req_voxel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scale_index (rsp_scale_index),
      .rsp_box_count   (rsp_box_count),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Behavioural model of the counter. The register copies are updated when a
   // write is accepted, the volume state when a voxel word is accepted.
   // -------------------------------------------------------------------------
   logic [dbc3_pkg::DIM_W-1:0]    reg_dim_x, reg_dim_y, reg_dim_z;
   logic [dbc3_pkg::SCALES_W-1:0] reg_scales;
   logic [dbc3_pkg::VOXEL_W-1:0]  reg_object;
   int unsigned                   at_x, at_y, at_z;
   // Slab (plus one) in which each box column of each scale was last counted;
   // a column that is absent has never been counted in this volume.
   int unsigned                   slab_seen [int unsigned];
   logic [dbc3_pkg::COUNT_W-1:0]  tally [MAX_SCALES];
   count_word_type                expected_counts [$];

   int unsigned cycle_count     = 0;
   int unsigned error_count     = 0;
   int unsigned voxels_sent     = 0;
   int unsigned volumes_closed  = 0;
   int unsigned words_predicted = 0;
   int unsigned words_checked   = 0;
   int unsigned src_idle_pct    = 0;
   int unsigned sink_idle_pct   = 0;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned lo,
                                            int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void clear_volume();
      at_x = 0;
      at_y = 0;
      at_z = 0;
      slab_seen.delete();
      foreach (tally[s]) tally[s] = '0;
   endfunction

   function automatic void reset_model();
      reg_dim_x  = dbc3_pkg::DIM_RST;
      reg_dim_y  = dbc3_pkg::DIM_RST;
      reg_dim_z  = dbc3_pkg::DIM_RST;
      reg_scales = dbc3_pkg::SCALES_RST;
      reg_object = dbc3_pkg::OBJECT_RST;
      clear_volume();
   endfunction

   function automatic void apply_reg(logic [dbc3_pkg::CSR_INDEX_W-1:0] index,
                                     logic [dbc3_pkg::CSR_DATA_W-1:0] data);
      case (index)
         dbc3_pkg::CSR_DIM_X:        reg_dim_x  = data[dbc3_pkg::DIM_W-1:0];
         dbc3_pkg::CSR_DIM_Y:        reg_dim_y  = data[dbc3_pkg::DIM_W-1:0];
         dbc3_pkg::CSR_DIM_Z:        reg_dim_z  = data[dbc3_pkg::DIM_W-1:0];
         dbc3_pkg::CSR_NUM_SCALES:   reg_scales = data[dbc3_pkg::SCALES_W-1:0];
         dbc3_pkg::CSR_OBJECT_VALUE: reg_object = data[dbc3_pkg::VOXEL_W-1:0];
         default: ;
      endcase
   endfunction

   // For an object voxel, marks every box that it falls in, at all scales, and
   // on the final voxel of a volume queues one count word per reported scale.
   function automatic void tally_voxel(logic [dbc3_pkg::VOXEL_W-1:0] v);
      int unsigned    dx, dy, dz, base, sh, row, bx, by, tag, key, ns;
      logic           hit;
      count_word_type word;
      dx   = clamp_to(reg_dim_x, 1, MAX_DIM);
      dy   = clamp_to(reg_dim_y, 1, MAX_DIM);
      dz   = clamp_to(reg_dim_z, 1, MAX_DIM);
      hit  = (v == reg_object);
      base = 0;
      for (int s = 0; s < MAX_SCALES; s++) begin
         sh  = s + 1;
         row = (MAX_DIM + (1 << sh) - 1) >> sh;
         bx  = at_x >> sh;
         by  = at_y >> sh;
         tag = (at_z >> sh) + 1;
         key = base + by * row + bx;
         if (hit && bx < row && by < row) begin
            if (!slab_seen.exists(key) || slab_seen[key] != tag) begin
               slab_seen[key] = tag;
               if (tally[s] != dbc3_pkg::COUNT_MAX) tally[s] = tally[s] + 1'b1;
            end
         end
         base += row * row;
      end

      if (at_x + 1 >= dx && at_y + 1 >= dy && at_z + 1 >= dz) begin
         ns = clamp_to(reg_scales, 1, MAX_SCALES);
         for (int s = 0; s < ns; s++) begin
            word.scale = dbc3_pkg::SCALE_IDX_W'(s);
            word.count = tally[s];
            word.last  = (s + 1 == ns);
            expected_counts.push_back(word);
         end
         words_predicted += ns;
         volumes_closed++;
         clear_volume();
      end else if (at_x + 1 < dx) begin
         at_x++;
      end else begin
         at_x = 0;
         if (at_y + 1 < dy) begin
            at_y++;
         end else begin
            at_y = 0;
            at_z++;
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Clock, cycle limit and the receiving side.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The stall is redrawn at every falling edge, so that it lands on every
   // phase of the counter's work, including the sweep that follows a volume.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < sink_idle_pct);
   end

   // Each count word taken is held against the oldest prediction.
   always @(posedge clock) begin : check_counts
      count_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("unexpected count word: scale_index %0d, box_count %0d, last %0d",
                   rsp_scale_index, rsp_box_count, rsp_last);
            error_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_scale_index !== want.scale) begin
               $error("scale_index: expected %0d, got %0d", want.scale, rsp_scale_index);
               error_count++;
            end
            if (rsp_box_count !== want.count) begin
               $error("box_count: expected %0d, got %0d", want.count, rsp_box_count);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
         words_checked++;
      end
   end

   // -------------------------------------------------------------------------
   // Shared driving tasks. Each one starts and ends just after a falling
   // edge, so that voxel words can follow one another back to back.
   // -------------------------------------------------------------------------
   task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
   endtask

   task automatic send_voxel(input logic [dbc3_pkg::VOXEL_W-1:0] v);
      while ($urandom_range(99) < src_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_voxel = v;
      do @(posedge clock); while (req_stall);
      tally_voxel(v);
      voxels_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [dbc3_pkg::CSR_INDEX_W-1:0] index,
                            input logic [dbc3_pkg::CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Holds the sender back until every predicted count word has been taken,
   // then lets the pipeline empty before anything else happens.
   task automatic drain();
      while (expected_counts.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // Random bits above the width of a narrow register; they must be ignored.
   function automatic logic [dbc3_pkg::CSR_DATA_W-1:0] junk_above(int unsigned width);
      return dbc3_pkg::CSR_DATA_W'($urandom) << width;
   endfunction

   // Configures a whole volume and streams it. The sizes are register values,
   // so zero stands for one; hit_pct sets how often a voxel is object matter.
   task automatic run_volume(input int unsigned nx, input int unsigned ny,
                             input int unsigned nz, input int unsigned scales,
                             input logic [dbc3_pkg::VOXEL_W-1:0] object,
                             input int unsigned hit_pct);
      int unsigned total;
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(nx));
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(ny));
      write_reg(dbc3_pkg::CSR_DIM_Z, dbc3_pkg::CSR_DATA_W'(nz));
      write_reg(dbc3_pkg::CSR_NUM_SCALES,
                junk_above(dbc3_pkg::SCALES_W) | dbc3_pkg::CSR_DATA_W'(scales));
      write_reg(dbc3_pkg::CSR_OBJECT_VALUE,
                junk_above(dbc3_pkg::VOXEL_W) | dbc3_pkg::CSR_DATA_W'(object));
      total = clamp_to(nx, 1, MAX_DIM) * clamp_to(ny, 1, MAX_DIM) *
              clamp_to(nz, 1, MAX_DIM);
      repeat (total) begin
         if ($urandom_range(99) < hit_pct) send_voxel(object);
         else send_voxel(dbc3_pkg::VOXEL_W'($urandom_range(255)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // Reset values: a few voxels under the default registers, then the
   // dimensions are shrunk mid-volume (zero standing for one) so that the
   // next voxel closes the volume and all eight scales are reported.
   task automatic test_reset_defaults();
      set_idling(32, 87);
      send_voxel(8'hFF);
      send_voxel(8'h00);
      send_voxel(8'h80);
      send_voxel(8'hFF);
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, '0);
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(1));
      write_reg(dbc3_pkg::CSR_DIM_Z, '0);
      send_voxel(8'hFF);
   endtask

   // Voxel extremes and every bit both ways, object value zero, and a scale
   // count of zero that must report scale 0 only. The spare register indexes
   // are written with zero afterwards; a decoder that aliased them onto a
   // dimension would shrink the volume and show up as a mismatch.
   task automatic test_voxel_extremes();
      logic [dbc3_pkg::VOXEL_W-1:0] pattern [12] = '{
         8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0,
         8'h00, 8'h01, 8'h80, 8'h00, 8'hFE, 8'h00};
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(2));
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(2));
      write_reg(dbc3_pkg::CSR_DIM_Z, dbc3_pkg::CSR_DATA_W'(3));
      write_reg(dbc3_pkg::CSR_NUM_SCALES, '0);
      write_reg(dbc3_pkg::CSR_OBJECT_VALUE, '0);
      for (int unsigned idx = dbc3_pkg::CSR_OBJECT_VALUE + 1; idx <= CSR_TOP_INDEX; idx++)
         write_reg(dbc3_pkg::CSR_INDEX_W'(idx), '0);
      foreach (pattern[i]) send_voxel(pattern[i]);
   endtask

   // Registers changed mid-volume: x shrinks below the current position and
   // must wrap on the next advance, then y and z shrink behind the current
   // row so that the volume closes as soon as x reaches its last value.
   task automatic test_shrink_mid_volume();
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(4));
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(4));
      write_reg(dbc3_pkg::CSR_DIM_Z, dbc3_pkg::CSR_DATA_W'(2));
      write_reg(dbc3_pkg::CSR_NUM_SCALES,
                junk_above(dbc3_pkg::SCALES_W) | dbc3_pkg::CSR_DATA_W'(15));
      write_reg(dbc3_pkg::CSR_OBJECT_VALUE, dbc3_pkg::CSR_DATA_W'(8'h5A));
      for (int i = 0; i < 6; i++)
         send_voxel((i % 3 == 0) ? 8'h5A : dbc3_pkg::VOXEL_W'(i));
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(2));
      for (int i = 0; i < 3; i++) send_voxel((i == 1) ? 8'h5A : 8'hA5);
      drain();
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(1));
      write_reg(dbc3_pkg::CSR_DIM_Z, dbc3_pkg::CSR_DATA_W'(1));
      send_voxel(8'h5A);
      send_voxel(8'h00);
   endtask

   // Largest sizes: x is written as 1023 so that the upper clamp applies, and
   // the row is cut short by a mid-volume shrink of x, with even the biggest
   // boxes clipped by y and z. Then y and z at their top values, cut short
   // the same way.
   task automatic test_largest_volumes();
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(1023));
      write_reg(dbc3_pkg::CSR_DIM_Y, '0);
      write_reg(dbc3_pkg::CSR_DIM_Z, '0);
      write_reg(dbc3_pkg::CSR_NUM_SCALES,
                junk_above(dbc3_pkg::SCALES_W) | dbc3_pkg::CSR_DATA_W'(MAX_SCALES));
      write_reg(dbc3_pkg::CSR_OBJECT_VALUE, dbc3_pkg::CSR_DATA_W'($urandom_range(255)));
      repeat (8) send_voxel(($urandom_range(2) == 0) ? reg_object : 8'h00);
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(1));
      send_voxel(reg_object);
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(2));
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(MAX_DIM));
      write_reg(dbc3_pkg::CSR_DIM_Z, dbc3_pkg::CSR_DATA_W'(1023));
      repeat (10) send_voxel(($urandom_range(2) == 0) ? reg_object : 8'h00);
      drain();
      write_reg(dbc3_pkg::CSR_DIM_X, dbc3_pkg::CSR_DATA_W'(1));
      write_reg(dbc3_pkg::CSR_DIM_Y, dbc3_pkg::CSR_DATA_W'(1));
      write_reg(dbc3_pkg::CSR_DIM_Z, dbc3_pkg::CSR_DATA_W'(1));
      send_voxel(reg_object);
   endtask

   // Random volumes until the voxel and count word goals of one idling
   // pattern are met. Most volumes are small cuboids; about one in four is a
   // long thin one that gives the larger scales something to count.
   task automatic random_volumes(input int unsigned src_pct, input int unsigned sink_pct,
                                 input int unsigned voxel_goal,
                                 input int unsigned word_goal);
      int unsigned voxels_at_start, words_at_start;
      voxels_at_start = voxels_sent;
      words_at_start  = words_predicted;
      set_idling(src_pct, sink_pct);
      while (voxels_sent - voxels_at_start < voxel_goal ||
             words_predicted - words_at_start < word_goal) begin
         if ($urandom_range(3) == 0)
            run_volume($urandom_range(9, 20), $urandom_range(0, 2), $urandom_range(0, 1),
                       $urandom_range(0, 15), dbc3_pkg::VOXEL_W'($urandom_range(255)),
                       $urandom_range(4) * 25);
         else
            run_volume($urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 2),
                       $urandom_range(0, 15), dbc3_pkg::VOXEL_W'($urandom_range(255)),
                       $urandom_range(4) * 25);
      end
   endtask

   task automatic test_random_volumes();
      random_volumes(32, 87, 16, 8);
      random_volumes(87, 32, 16, 8);
      random_volumes(0, 0, 16, 8);
   endtask

   // -------------------------------------------------------------------------
   // Sequence of the run. Reset is held from the start and released at a
   // falling edge; the counter then sweeps its mark memories with req_stall
   // high, which the first voxel word simply waits out.
   // -------------------------------------------------------------------------
   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_voxel_extremes();
      test_shrink_mid_volume();
      test_largest_volumes();
      test_random_volumes();

      set_idling(0, 0);
      drain();
      $display("Streamed %0d voxels over %0d volumes; %0d count words compared.",
               voxels_sent, volumes_closed, words_checked);
      $display("Register extremes, mid-volume resizing and three stall patterns exercised.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
